FILE: hdl/fsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_pkg
// shared constants, types and helpers of the forth stack alu
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int STACK_SLOTS = 1024;
  localparam int WORD_BITS   = 32;
  localparam int DEPTH_W     = $clog2(STACK_SLOTS);
  localparam int CNT_W       = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [DEPTH_W-1:0]   depth_t;

  // usable entries per stack
  localparam depth_t CAPACITY = DEPTH_W'(STACK_SLOTS - 1);

  typedef enum logic [4:0] {
    OP_LIT   = 5'd0,
    OP_ZRET  = 5'd1,
    OP_TOR   = 5'd2,
    OP_FROMR = 5'd3,
    OP_LT    = 5'd4,
    OP_EQ    = 5'd5,
    OP_ADD   = 5'd6,
    OP_SUB   = 5'd7,
    OP_MUL   = 5'd8,
    OP_DIV   = 5'd9,
    OP_MOD   = 5'd10,
    OP_AND   = 5'd11,
    OP_OR    = 5'd12,
    OP_XOR   = 5'd13,
    OP_NOT   = 5'd14,
    OP_DROP  = 5'd15,
    OP_DUP   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_PRINT = 5'd18
  } kind_e;

  typedef enum logic [2:0] {
    FLT_OK       = 3'd0,
    FLT_DATA_OVF = 3'd1,
    FLT_DATA_UNF = 3'd2,
    FLT_RET_OVF  = 3'd3,
    FLT_RET_UNF  = 3'd4,
    FLT_DIV_ZERO = 3'd5
  } fault_e;

  // low 32 bits of a word, zero filled when the word is narrower
  function automatic logic [31:0] word_lo32(input word_t w);
    logic [WORD_BITS+31:0] t;
    t = {32'b0, w};
    return t[31:0];
  endfunction

  // low 10 bits of a depth count
  function automatic logic [9:0] depth_lo10(input depth_t d);
    logic [DEPTH_W+9:0] t;
    t = {10'b0, d};
    return t[9:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/forth_stack_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// forth_stack_alu
// execution unit of a forth-style machine with data and return stacks
// ----------------------------------------------------------------------------
// one item is one opcode plus a literal; it yields one result item with the
// new data stack top, both depths, a print value, the early-return flag and a
// fault code. the top of the data stack lives in a register, the entries
// below it and the whole return stack live in two synchronous rams. the
// accept edge issues the ram reads (second data entry and return top); the
// execute state applies the opcode and writes back once the output can take
// the result. div and mod with a nonzero divisor first wait in ST_DIV for
// the bit-serial divider. a new item is taken once the previous one has
// committed, even while its result is still stalled in the output register.
// ----------------------------------------------------------------------------
module forth_stack_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [4:0]  kind_i,
  input  wire logic signed [31:0] value_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic signed [31:0] top_value_o,
  output      logic [9:0]  data_count_o,
  output      logic [9:0]  return_count_o,
  output      logic        printed_o,
  output      logic signed [31:0] print_value_o,
  output      logic        leave_word_o,
  output      logic [2:0]  fault_o
);
  import fsa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV} state_e;

  state_e state_q, state_d;

  // architectural state: depths and the cached data top
  depth_t dcnt_q, dcnt_d;
  depth_t rcnt_q, rcnt_d;
  word_t  tos_q, tos_d;

  // latched item
  kind_e  kind_q;
  word_t  lit_q;
  logic   div_ok_q, div_ok_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] top_q, pval_q;
  logic [9:0]  dcount_q, rcount_q;
  logic        printed_q, leave_q;
  fault_e      fault_q;

  // ram ports
  logic   d_we, r_we;
  depth_t d_waddr, r_waddr;
  word_t  d_wdata, r_wdata;
  word_t  d_rdata, r_rdata;
  logic   in_acc;

  // divider
  logic  div_start, div_done;
  word_t div_quo, div_rem;
  word_t mag_a, mag_b;

  // execute-stage values
  logic   has1, has2;
  word_t  a, b, rv, alu_res;
  depth_t pop1, pop2;
  logic   commit, need_div;
  logic   printed_n, leave_n;
  word_t  pval_n;
  fault_e fault_n;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // entries below the top: the second data entry, the return top
  fsa_ram #(.DEPTH(STACK_SLOTS), .WIDTH(WORD_BITS)) u_dram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (in_acc),
    .raddr_i (dcnt_q - DEPTH_W'(2)),
    .rdata_o (d_rdata)
  );

  fsa_ram #(.DEPTH(STACK_SLOTS), .WIDTH(WORD_BITS)) u_rram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (in_acc),
    .raddr_i (rcnt_q - DEPTH_W'(1)),
    .rdata_o (r_rdata)
  );

  // operand fetch, empty slots read as zero
  assign has1 = (dcnt_q != '0);
  assign has2 = (dcnt_q > DEPTH_W'(1));
  assign a    = has1 ? tos_q : '0;
  assign b    = has2 ? d_rdata : '0;
  assign rv   = (rcnt_q != '0) ? r_rdata : '0;
  assign pop1 = has1 ? dcnt_q - DEPTH_W'(1) : '0;
  assign pop2 = has2 ? dcnt_q - DEPTH_W'(2) : '0;

  assign mag_a = a[WORD_BITS-1] ? word_t'(-a) : a;
  assign mag_b = b[WORD_BITS-1] ? word_t'(-b) : b;

  fsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_b),
    .divisor_i  (mag_a),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // binary alu, b op a
  always_comb begin
    case (kind_q)
      OP_LT:   alu_res = ($signed(b) < $signed(a)) ? '1 : '0;
      OP_EQ:   alu_res = (b == a) ? '1 : '0;
      OP_ADD:  alu_res = b + a;
      OP_SUB:  alu_res = b - a;
      OP_MUL:  alu_res = b * a;
      OP_DIV: begin
        if (a == '0) alu_res = '0;
        else alu_res = (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? word_t'(-div_quo) : div_quo;
      end
      OP_MOD: begin
        if (a == '0) alu_res = '0;
        else alu_res = b[WORD_BITS-1] ? word_t'(-div_rem) : div_rem;
      end
      OP_AND:  alu_res = b & a;
      OP_OR:   alu_res = b | a;
      OP_XOR:  alu_res = b ^ a;
      default: alu_res = '0;
    endcase
  end

  assign need_div = (kind_q == OP_DIV || kind_q == OP_MOD) && (a != '0) && !div_ok_q;
  assign commit   = (state_q == ST_EXEC) && !need_div && !(out_valid_q && out_stall_i);
  assign div_start = (state_q == ST_EXEC) && need_div;

  // opcode semantics; only committed when commit is high
  always_comb begin
    dcnt_d    = dcnt_q;
    rcnt_d    = rcnt_q;
    tos_d     = tos_q;
    d_we      = 1'b0;
    d_waddr   = dcnt_q - DEPTH_W'(1);
    d_wdata   = tos_q;
    r_we      = 1'b0;
    r_waddr   = rcnt_q;
    r_wdata   = a;
    printed_n = 1'b0;
    leave_n   = 1'b0;
    pval_n    = '0;
    fault_n   = FLT_OK;
    unique case (kind_q)
      OP_LIT, OP_FROMR: begin
        if (kind_q == OP_FROMR) begin
          if (rcnt_q == '0) fault_n = FLT_RET_UNF;
          else rcnt_d = rcnt_q - DEPTH_W'(1);
        end
        if (dcnt_q < CAPACITY) begin
          d_we   = has1;
          tos_d  = (kind_q == OP_LIT) ? lit_q : rv;
          dcnt_d = dcnt_q + DEPTH_W'(1);
        end else if (fault_n == FLT_OK) begin
          fault_n = FLT_DATA_OVF;
        end
      end
      OP_ZRET: begin
        if (a == '0) begin
          leave_n = 1'b1;
          dcnt_d  = pop1;
          tos_d   = d_rdata;
          if (!has1) fault_n = FLT_DATA_UNF;
        end
      end
      OP_TOR: begin
        dcnt_d = pop1;
        tos_d  = d_rdata;
        if (!has1) fault_n = FLT_DATA_UNF;
        if (rcnt_q < CAPACITY) begin
          r_we   = 1'b1;
          rcnt_d = rcnt_q + DEPTH_W'(1);
        end else if (fault_n == FLT_OK) begin
          fault_n = FLT_RET_OVF;
        end
      end
      OP_LT, OP_EQ, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_AND, OP_OR, OP_XOR: begin
        dcnt_d = pop2 + DEPTH_W'(1);
        tos_d  = alu_res;
        if (!has2) fault_n = FLT_DATA_UNF;
        else if ((kind_q == OP_DIV || kind_q == OP_MOD) && a == '0) fault_n = FLT_DIV_ZERO;
      end
      OP_NOT: begin
        dcnt_d = pop1 + DEPTH_W'(1);
        tos_d  = ~a;
        if (!has1) fault_n = FLT_DATA_UNF;
      end
      OP_DROP, OP_PRINT: begin
        dcnt_d = pop1;
        tos_d  = d_rdata;
        if (!has1) fault_n = FLT_DATA_UNF;
        if (kind_q == OP_PRINT) begin
          printed_n = 1'b1;
          pval_n    = a;
        end
      end
      OP_DUP: begin
        tos_d = a;
        if (!has1) fault_n = FLT_DATA_UNF;
        if (pop1 + DEPTH_W'(1) < CAPACITY) begin
          d_we    = 1'b1;
          d_waddr = pop1;
          d_wdata = a;
          dcnt_d  = pop1 + DEPTH_W'(2);
        end else begin
          dcnt_d = pop1 + DEPTH_W'(1);
          if (fault_n == FLT_OK) fault_n = FLT_DATA_OVF;
        end
      end
      OP_SWAP: begin
        d_we    = 1'b1;
        d_waddr = pop2;
        d_wdata = a;
        tos_d   = b;
        dcnt_d  = pop2 + DEPTH_W'(2);
        if (!has2) fault_n = FLT_DATA_UNF;
      end
      default: begin
      end
    endcase
    if (!commit) begin
      d_we = 1'b0;
      r_we = 1'b0;
    end
  end

  // sequencing
  always_comb begin
    state_d     = state_q;
    div_ok_d    = div_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_EXEC;
      ST_EXEC: begin
        if (div_start) begin
          state_d = ST_DIV;
        end else if (commit) begin
          state_d     = ST_IDLE;
          div_ok_d    = 1'b0;
          out_valid_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d  = ST_EXEC;
          div_ok_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      rcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      div_ok_q    <= div_ok_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        dcnt_q <= dcnt_d;
        rcnt_q <= rcnt_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_e'(kind_i);
      lit_q  <= WORD_BITS'(value_i);
    end
    if (commit) begin
      tos_q     <= tos_d;
      top_q     <= (dcnt_d != '0) ? word_lo32(tos_d) : 32'd0;
      dcount_q  <= depth_lo10(dcnt_d);
      rcount_q  <= depth_lo10(rcnt_d);
      printed_q <= printed_n;
      pval_q    <= word_lo32(pval_n);
      leave_q   <= leave_n;
      fault_q   <= fault_n;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign top_value_o    = top_q;
  assign data_count_o   = dcount_q;
  assign return_count_o = rcount_q;
  assign printed_o      = printed_q;
  assign print_value_o  = pval_q;
  assign leave_word_o   = leave_q;
  assign fault_o        = fault_q;

endmodule
`default_nettype wire

FILE: hdl/fsa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fsa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsa_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire fsa_pkg::word_t dividend_i,
  input  wire fsa_pkg::word_t divisor_i,
  output      logic          done_o,
  output      fsa_pkg::word_t quo_o,
  output      fsa_pkg::word_t rem_o
);
  import fsa_pkg::*;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  word_t              quo_q, quo_d;
  word_t              rem_q, rem_d;
  word_t              dvs_q, dvs_d;
  logic [WORD_BITS:0] shifted;
  logic [WORD_BITS:0] diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[WORD_BITS-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[WORD_BITS]) begin
        rem_d = diff[WORD_BITS-1:0];
        quo_d = {quo_q[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_BITS-1:0];
        quo_d = {quo_q[WORD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

FILE: tb/fsa_checker.sv
// ----------------------------------------------------------------------------
// fsa_checker
// watches both channels of the stack alu, predicts every result item and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module fsa_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [4:0]         kind_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] top_value_i,
  input  logic [9:0]         data_count_i,
  input  logic [9:0]         return_count_i,
  input  logic               printed_i,
  input  logic signed [31:0] print_value_i,
  input  logic               leave_word_i,
  input  logic [2:0]         fault_i,
  output int                 errors_o,
  output int                 pending_o
);
  import fsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] top;
    logic [9:0]  dcnt;
    logic [9:0]  rcnt;
    logic        printed;
    logic [31:0] pval;
    logic        leave;
    logic [2:0]  fault;
  } step_result_t;

  word_t        dstk [CAPACITY];
  word_t        rstk [CAPACITY];
  int unsigned  ddep, rdep;
  fault_e       step_flt;
  step_result_t expected_q[$];
  int           errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic void flag(fault_e f);
    if (step_flt == FLT_OK) step_flt = f;
  endfunction

  function automatic void dpush(word_t v);
    if (ddep >= CAPACITY) flag(FLT_DATA_OVF);
    else begin
      dstk[ddep] = v;
      ddep++;
    end
  endfunction

  function automatic word_t dpop();
    if (ddep == 0) begin
      flag(FLT_DATA_UNF);
      return '0;
    end
    ddep--;
    return dstk[ddep];
  endfunction

  // signed divide with zero check; remainder follows the dividend sign
  function automatic word_t sdiv(word_t b, word_t a, bit rem);
    logic signed [WORD_BITS:0] sb, sa;
    if (a == 0) begin
      flag(FLT_DIV_ZERO);
      return '0;
    end
    sb = $signed({b[WORD_BITS-1], b});
    sa = $signed({a[WORD_BITS-1], a});
    return rem ? word_t'(sb % sa) : word_t'(sb / sa);
  endfunction

  function automatic step_result_t execute_opcode(logic [4:0] kind, logic [31:0] lit);
    word_t        a, b, pv;
    step_result_t r;
    a = '0; b = '0; pv = '0;
    r = '0;
    step_flt = FLT_OK;
    case (kind)
      OP_LIT:   dpush(word_t'(signed'(lit)));
      OP_ZRET: begin
        a = dpop();
        if (a == 0) r.leave = 1'b1; else dpush(a);
      end
      OP_TOR: begin
        a = dpop();
        if (rdep >= CAPACITY) flag(FLT_RET_OVF);
        else begin rstk[rdep] = a; rdep++; end
      end
      OP_FROMR: begin
        if (rdep == 0) begin flag(FLT_RET_UNF); a = '0; end
        else begin rdep--; a = rstk[rdep]; end
        dpush(a);
      end
      OP_LT:   begin a = dpop(); b = dpop(); dpush(($signed(b) < $signed(a)) ? '1 : '0); end
      OP_EQ:   begin a = dpop(); b = dpop(); dpush((b == a) ? '1 : '0); end
      OP_ADD:  begin a = dpop(); b = dpop(); dpush(b + a); end
      OP_SUB:  begin a = dpop(); b = dpop(); dpush(b - a); end
      OP_MUL:  begin a = dpop(); b = dpop(); dpush(b * a); end
      OP_DIV:  begin a = dpop(); b = dpop(); dpush(sdiv(b, a, 1'b0)); end
      OP_MOD:  begin a = dpop(); b = dpop(); dpush(sdiv(b, a, 1'b1)); end
      OP_AND:  begin a = dpop(); b = dpop(); dpush(b & a); end
      OP_OR:   begin a = dpop(); b = dpop(); dpush(b | a); end
      OP_XOR:  begin a = dpop(); b = dpop(); dpush(b ^ a); end
      OP_NOT:  begin a = dpop(); dpush(~a); end
      OP_DROP: a = dpop();
      OP_DUP:  begin a = dpop(); dpush(a); dpush(a); end
      OP_SWAP: begin a = dpop(); b = dpop(); dpush(a); dpush(b); end
      OP_PRINT: begin pv = dpop(); r.printed = 1'b1; end
      default: ;
    endcase
    r.top   = (ddep > 0) ? 32'(dstk[ddep-1]) : '0;
    r.dcnt  = 10'(ddep);
    r.rcnt  = 10'(rdep);
    r.pval  = 32'(pv);
    r.fault = step_flt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t got, want;
    if (!rst_ni) begin
      ddep = 0;
      rdep = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(execute_opcode(kind_i, value_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{top_value_i, data_count_i, return_count_i, printed_i,
                print_value_i, leave_word_i, fault_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.top != want.top) begin
            $display("%0t: top_value exp %h got %h", $time, want.top, got.top); errors++;
          end
          if (got.dcnt != want.dcnt) begin
            $display("%0t: data_count exp %0d got %0d", $time, want.dcnt, got.dcnt); errors++;
          end
          if (got.rcnt != want.rcnt) begin
            $display("%0t: return_count exp %0d got %0d", $time, want.rcnt, got.rcnt);
            errors++;
          end
          if (got.printed != want.printed) begin
            $display("%0t: printed exp %b got %b", $time, want.printed, got.printed); errors++;
          end
          if (got.pval != want.pval) begin
            $display("%0t: print_value exp %h got %h", $time, want.pval, got.pval); errors++;
          end
          if (got.leave != want.leave) begin
            $display("%0t: leave_word exp %b got %b", $time, want.leave, got.leave); errors++;
          end
          if (got.fault != want.fault) begin
            $display("%0t: fault exp %0d got %0d", $time, want.fault, got.fault); errors++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_forth_stack_alu.sv
// ----------------------------------------------------------------------------
// tb_forth_stack_alu
// stimulus and verdict for the forth stack alu; a checker beside the block
// predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_forth_stack_alu;
  import fsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [4:0]         kind_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic signed [31:0] top_value_o, print_value_o;
  logic [9:0]         data_count_o, return_count_o;
  logic               printed_o, leave_word_o;
  logic [2:0]         fault_o;
  int                 errors, pending;
  bit                 hold_off = 1'b0;

  always #1 clk_i = ~clk_i;

  forth_stack_alu u_dut (.*);

  fsa_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .top_value_i(top_value_o),
    .data_count_i(data_count_o), .return_count_i(return_count_o),
    .printed_i(printed_o), .print_value_i(print_value_o),
    .leave_word_i(leave_word_o), .fault_i(fault_o),
    .errors_o(errors), .pending_o(pending)
  );

  // tracked depth, used only to steer random opcodes toward useful states
  int shadow_depth = 0;
  int shadow_rdepth = 0;
  int gap_left = 0;
  int burst_left = 0;

  // offer one item and hold it until accepted; bursts and gaps around it
  task automatic send_item(logic [4:0] kind, logic [31:0] lit);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
    end
    gap_left = 0;
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= lit;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // words that stress the arithmetic corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 9) - 5;
      default: return $urandom;
    endcase
  endfunction

  // receiver: stall pattern of its own, plus a long hold-off when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else out_stall_i <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
    end
  end

  initial begin
    logic [4:0] k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-stack pops, every opcode, division corners
    send_item(OP_DROP, 0);
    send_item(OP_PRINT, 0);
    send_item(OP_ZRET, 0);
    send_item(OP_FROMR, 0);
    send_item(OP_ADD, 0);
    send_item(OP_DIV, 0);
    send_item(OP_LIT, 32'h8000_0000);
    send_item(OP_LIT, 32'hffff_ffff);
    send_item(OP_DUP, 0);
    send_item(OP_TOR, 0);
    send_item(OP_DIV, 0);                 // most negative / -1
    send_item(OP_FROMR, 0);
    send_item(OP_MOD, 0);
    send_item(OP_LIT, 32'h7fff_ffff);
    send_item(OP_LIT, 0);
    send_item(OP_MOD, 0);                 // modulo by zero
    send_item(OP_LIT, -7);
    send_item(OP_LIT, 2);
    send_item(OP_SWAP, 0);
    send_item(OP_DIV, 0);
    send_item(OP_ZRET, 0);
    send_item(5'd25, 32'h1234_5678);      // unused opcode
    send_item(5'd31, 0);
    for (int i = 4; i <= 18; i++) send_item(5'(i), $urandom);

    // random: mostly literal pushes feeding operators, some noise
    for (int i = 0; i < 150; i++) begin
      if (shadow_depth < 3 && $urandom_range(0, 9) < 8) k = OP_LIT;
      else if ($urandom_range(0, 19) == 0) k = 5'($urandom);
      else k = 5'($urandom_range(0, 18));
      send_item(k, pick_word());
      case (k)
        OP_LIT, OP_DUP: shadow_depth++;
        OP_ZRET, OP_SWAP, OP_NOT: ;
        OP_TOR: begin shadow_depth--; shadow_rdepth++; end
        OP_FROMR: begin shadow_depth++; if (shadow_rdepth > 0) shadow_rdepth--; end
        OP_DROP, OP_PRINT: shadow_depth--;
        default: if (k <= OP_XOR) shadow_depth--;
      endcase
      if (shadow_depth < 0) shadow_depth = 0;
    end

    // fill the data stack to overflow, starting while the receiver holds off
    hold_off = 1'b1;
    fork
      begin repeat (200) @(posedge clk_i); hold_off = 1'b0; end
    join_none
    for (int i = 0; i < 1025; i++) send_item(OP_LIT, pick_word());
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
